@@ rtl/sparse_row_element_store_assert.svh @@
// Assertion helpers used by the block's top-level RTL file.
// Each helper expects clk_i and rst_ni in the enclosing module.
`ifndef SPARSE_ROW_ELEMENT_STORE_ASSERT_SVH
`define SPARSE_ROW_ELEMENT_STORE_ASSERT_SVH

// Same-cycle implication.
`define SRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sparse row store assertion failed");

// Next-cycle implication.
`define SRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse row store assertion failed");

`endif

@@ rtl/srs_pkg.sv @@
`default_nettype none
package srs_pkg;

  localparam int MAX_DIM      = 64;
  localparam int ROW_CAPACITY = 16;
  localparam int VALUE_BITS   = 32;

  localparam int ROW_W  = $clog2(MAX_DIM);
  localparam int SLOT_W = $clog2(ROW_CAPACITY);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ENT_AW = ROW_W + SLOT_W;
  localparam int SIZE_W = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_MISS     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_FULL     = 3'd5
  } srs_status_e;

  typedef struct packed {
    logic [ROW_W-1:0]             col;
    logic signed [VALUE_BITS-1:0] value;
  } srs_entry_t;

  typedef struct packed {
    logic              cnt_we;
    logic [ROW_W-1:0]  cnt_addr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    srs_entry_t        ent_wdata;
    logic [ENT_AW-1:0] ent_raddr;
  } srs_mem_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    srs_entry_t       entry;
  } srs_mem_rsp_t;

endpackage
`default_nettype wire

@@ rtl/srs_if.sv @@
`default_nettype none
interface srs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  row;
  logic [5:0]  col;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input cmd, input row, input col, input value,
                  output ready);
endinterface

interface srs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic signed [31:0] read_value;
  logic [3:0]  slot;

  modport source (output valid, output status, output found, output read_value,
                  output slot, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input slot, output ready);
endinterface
`default_nettype wire

@@ rtl/sparse_row_element_store.sv @@
// Sparse row element store: keeps a square sparse matrix of Q16.16 values, each row a
// column-sorted list of up to 16 entries in one shared entry memory. One command beat
// is taken at a time; a result beat follows on the output register, and the next
// command is taken while that result still waits. An in-range item passes count read,
// decide, result load and idle, plus a search step and a read per binary-search probe
// (at most 5) and one more search step on a miss; an insert or delete adds a read and
// a write per entry moved (at most 15) plus a check and a count update to close the row,
// all through the single registered read port of the entry memory, which the search
// and the shift share. Out-of-range items go straight to the result load. A result
// still waiting on the output holds the next item in its last state. Row counts start
// empty right after reset, with no clearing pass. The user must write matrix_size only
// while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "sparse_row_element_store_assert.svh"
module sparse_row_element_store import srs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  srs_in_if.sink                 req_i,
  srs_out_if.source              rsp_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_COUNT  = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_PROBE  = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_MV_RD  = 9'b000100000,
    S_MV_WR  = 9'b001000000,
    S_FINISH = 9'b010000000,
    S_DONE   = 9'b100000000
  } srs_state_e;

  srs_state_e state_q, state_d;

  logic [SIZE_W-1:0] size_q;
  logic              cmd_q, cmd_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  col_q, col_d;
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [SLOT_W-1:0] mid_q, mid_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              hit_q, hit_d;
  logic signed [VALUE_BITS-1:0] hval_q, hval_d;
  srs_status_e       status_q, status_d;

  logic              out_valid_q, out_valid_d;
  srs_status_e       out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  logic signed [VALUE_BITS-1:0] out_rval_q, out_rval_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  srs_mem_req_t mem_req;
  srs_mem_rsp_t mem_rsp;

  logic          accept;
  logic          out_load;
  logic [CNT_W:0] mid_sum;
  logic [CNT_W-1:0] k_up;
  logic [CNT_W-1:0] k_dn;
  logic          deleting;

  srs_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign k_up     = k_q + CNT_W'(1);
  assign k_dn     = k_q - CNT_W'(1);
  assign deleting = (status_q == ST_DELETED);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    row_d     = row_q;
    col_d     = col_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    pos_d     = pos_q;
    k_d       = k_q;
    hit_d     = hit_q;
    hval_d    = hval_q;
    status_d  = status_q;
    out_load  = 1'b0;

    mem_req           = '0;
    mem_req.cnt_addr  = row_q;
    mem_req.ent_raddr = {row_q, mid_q};
    mem_req.ent_waddr = {row_q, k_q[SLOT_W-1:0]};
    mem_req.ent_wdata = mem_rsp.entry;

    case (state_q)
      S_IDLE: begin
        mem_req.cnt_addr = req_i.row;
        if (accept) begin
          cmd_d = req_i.cmd;
          row_d = req_i.row;
          col_d = req_i.col;
          val_d = req_i.value;
          hit_d = 1'b0;
          if (({1'b0, req_i.row} >= size_q) || ({1'b0, req_i.col} >= size_q)) begin
            status_d = ST_RANGE;
            state_d  = S_DONE;
          end else begin
            state_d = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        cnt_d   = (mem_rsp.cnt > CNT_W'(ROW_CAPACITY)) ? CNT_W'(ROW_CAPACITY) : mem_rsp.cnt;
        lo_d    = '0;
        hi_d    = cnt_d;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          mid_d             = mid_sum[SLOT_W:1];
          mem_req.ent_raddr = {row_q, mid_d};
          state_d           = S_PROBE;
        end else begin
          pos_d   = lo_q;
          state_d = S_DECIDE;
        end
      end
      S_PROBE: begin
        if (mem_rsp.entry.col == col_q) begin
          hit_d   = 1'b1;
          pos_d   = {1'b0, mid_q};
          hval_d  = mem_rsp.entry.value;
          state_d = S_DECIDE;
        end else begin
          if (mem_rsp.entry.col < col_q) begin
            lo_d = {1'b0, mid_q} + CNT_W'(1);
          end else begin
            hi_d = {1'b0, mid_q};
          end
          state_d = S_SEARCH;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (cmd_q == CMD_READ) begin
          status_d = hit_q ? ST_UPDATED : ST_MISS;
        end else if (hit_q) begin
          if (val_q == '0) begin
            status_d = ST_DELETED;
            k_d      = pos_q;
            state_d  = S_MV_RD;
          end else begin
            status_d          = ST_UPDATED;
            mem_req.ent_we    = 1'b1;
            mem_req.ent_waddr = {row_q, pos_q[SLOT_W-1:0]};
            mem_req.ent_wdata = '{col: col_q, value: val_q};
          end
        end else if (val_q == '0) begin
          status_d = ST_MISS;
        end else if (cnt_q >= CNT_W'(ROW_CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          k_d      = cnt_q;
          state_d  = S_MV_RD;
        end
      end
      S_MV_RD: begin
        // Deletes pull entries down from the right; inserts push them up from the end.
        if (deleting) begin
          if (k_up < cnt_q) begin
            mem_req.ent_raddr = {row_q, k_up[SLOT_W-1:0]};
            state_d           = S_MV_WR;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          if (k_q > pos_q) begin
            mem_req.ent_raddr = {row_q, k_dn[SLOT_W-1:0]};
            state_d           = S_MV_WR;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_MV_WR: begin
        mem_req.ent_we = 1'b1;
        k_d            = deleting ? k_up : k_dn;
        state_d        = S_MV_RD;
      end
      S_FINISH: begin
        mem_req.cnt_we    = 1'b1;
        mem_req.cnt_wdata = deleting ? (cnt_q - CNT_W'(1)) : (cnt_q + CNT_W'(1));
        if (!deleting) begin
          mem_req.ent_we    = 1'b1;
          mem_req.ent_waddr = {row_q, pos_q[SLOT_W-1:0]};
          mem_req.ent_wdata = '{col: col_q, value: val_q};
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_rval_d   = out_rval_q;
    out_slot_d   = out_slot_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = status_q;
      out_found_d  = hit_q;
      out_rval_d   = ((cmd_q == CMD_READ) && hit_q) ? hval_q : '0;
      out_slot_d   = (hit_q || (status_q == ST_INSERTED)) ? pos_q[SLOT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SIZE_W'(MAX_DIM);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    row_q        <= row_d;
    col_q        <= col_d;
    val_q        <= val_d;
    cnt_q        <= cnt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    pos_q        <= pos_d;
    k_q          <= k_d;
    hit_q        <= hit_d;
    hval_q       <= hval_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_rval_q   <= out_rval_d;
    out_slot_q   <= out_slot_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_rval_q;
  assign rsp_o.slot       = out_slot_q;

  `SRS_ASSERT_IMP(a_no_write_when_idle, state_q == S_IDLE,
                  !mem_req.ent_we && !mem_req.cnt_we)
  `SRS_ASSERT_IMP(a_write_in_own_row, mem_req.ent_we, mem_req.ent_waddr[ENT_AW-1:SLOT_W] == row_q)
  `SRS_ASSERT_IMP(a_count_bounded, mem_req.cnt_we, mem_req.cnt_wdata <= CNT_W'(ROW_CAPACITY))
  `SRS_ASSERT_NXT(a_busy_after_accept, accept, state_q != S_IDLE)
  `SRS_ASSERT_IMP(a_range_result_clean, out_valid_q && (out_status_q == ST_RANGE),
                  !out_found_q && (out_slot_q == '0) && (out_rval_q == '0))

endmodule
`default_nettype wire

@@ rtl/srs_store.sv @@
`default_nettype none
module srs_store import srs_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire srs_mem_req_t req_i,
  output srs_mem_rsp_t rsp_o
);

  logic [CNT_W-1:0] cnt_mem [MAX_DIM];
  logic [MAX_DIM-1:0] cnt_vld_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic             vld_rd_q;

  srs_entry_t ent_mem [MAX_DIM*ROW_CAPACITY];
  srs_entry_t ent_rd_q;

  // A row whose count was never written reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      vld_rd_q  <= 1'b0;
    end else begin
      if (req_i.cnt_we) begin
        cnt_vld_q[req_i.cnt_addr] <= 1'b1;
      end
      vld_rd_q <= cnt_vld_q[req_i.cnt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[req_i.cnt_addr] <= req_i.cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[req_i.cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      ent_mem[req_i.ent_waddr] <= req_i.ent_wdata;
    end
    ent_rd_q <= ent_mem[req_i.ent_raddr];
  end

  assign rsp_o.cnt   = vld_rd_q ? cnt_rd_q : '0;
  assign rsp_o.entry = ent_rd_q;

endmodule
`default_nettype wire
